>>> src/apu_tone_channel_tick_assert.svh
// assertion macros shared by the tone channel rtl
`ifndef APU_TONE_CHANNEL_TICK_ASSERT_SVH
`define APU_TONE_CHANNEL_TICK_ASSERT_SVH

// next-cycle implication, held off during reset
`define APU_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

// same-cycle implication, held off during reset
`define APU_ASSERT_SAME(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

`endif

>>> src/apu_tct_pkg.sv
// types and constants for the apu tone channel
package apu_tct_pkg;

    localparam int unsigned CfgIdxW   = 3;
    localparam int unsigned CfgDataW  = 12;
    localparam int unsigned LevelW    = 4;
    localparam int unsigned CountW    = 13;
    localparam int unsigned PhaseW    = 5;
    localparam int unsigned LfsrW     = 15;
    localparam int unsigned WaveLenW  = 11;
    localparam int unsigned NoisePerW = 12;

    localparam logic [31:0]       DutyPatterns = 32'hF33C0C04;
    localparam logic [LevelW-1:0] MidLevel     = 4'd8;

    typedef enum logic [1:0] {
        KIND_PULSE0   = 2'd0,
        KIND_PULSE1   = 2'd1,
        KIND_TRIANGLE = 2'd2,
        KIND_NOISE    = 2'd3
    } t_kind;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_KIND         = 3'd0,
        CFG_WAVE_LENGTH  = 3'd1,
        CFG_DUTY_SELECT  = 3'd2,
        CFG_CONST_VOLUME = 3'd3,
        CFG_FIXED_VOLUME = 3'd4,
        CFG_NOISE_MODE   = 3'd5,
        CFG_NOISE_PERIOD = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        t_kind                 kind;
        logic [WaveLenW-1:0]   wave_length;
        logic [1:0]            duty_select;
        logic                  constant_volume;
        logic [LevelW-1:0]     fixed_volume;
        logic                  noise_mode;
        logic [NoisePerW-1:0]  noise_period;
    } t_cfg;

    typedef struct packed {
        logic              channel_enabled;
        logic              length_active;
        logic              linear_active;
        logic [LevelW-1:0] envelope_level;
    } t_item;

endpackage

>>> src/apu_tct_in_if.sv
// input tick channel
interface apu_tct_in_if;
    logic       valid;
    logic       ready;
    logic       channel_enabled;
    logic       length_active;
    logic       linear_active;
    logic [3:0] envelope_level;

    modport source (
        output valid, channel_enabled, length_active, linear_active, envelope_level,
        input  ready
    );
    modport sink (
        input  valid, channel_enabled, length_active, linear_active, envelope_level,
        output ready
    );
endinterface

>>> src/apu_tct_out_if.sv
// output sample channel
interface apu_tct_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] sample;

    modport source (output valid, sample, input ready);
    modport sink (input valid, sample, output ready);
endinterface

>>> src/apu_tct_cfg.sv
// configuration register file
module apu_tct_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [apu_tct_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [apu_tct_pkg::CfgDataW-1:0]   i_cfg_data,
    output apu_tct_pkg::t_cfg                  o_cfg
);

    apu_tct_pkg::t_cfg r_cfg;
    apu_tct_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (apu_tct_pkg::t_cfg_idx'(i_cfg_idx))
                apu_tct_pkg::CFG_KIND:
                    n_cfg.kind = apu_tct_pkg::t_kind'(i_cfg_data[1:0]);
                apu_tct_pkg::CFG_WAVE_LENGTH:
                    n_cfg.wave_length = i_cfg_data[apu_tct_pkg::WaveLenW-1:0];
                apu_tct_pkg::CFG_DUTY_SELECT:
                    n_cfg.duty_select = i_cfg_data[1:0];
                apu_tct_pkg::CFG_CONST_VOLUME:
                    n_cfg.constant_volume = i_cfg_data[0];
                apu_tct_pkg::CFG_FIXED_VOLUME:
                    n_cfg.fixed_volume = i_cfg_data[apu_tct_pkg::LevelW-1:0];
                apu_tct_pkg::CFG_NOISE_MODE:
                    n_cfg.noise_mode = i_cfg_data[0];
                apu_tct_pkg::CFG_NOISE_PERIOD:
                    n_cfg.noise_period = i_cfg_data[apu_tct_pkg::NoisePerW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> src/apu_tct_wave.sv
// wave counter, sequencer state and level generation
`include "apu_tone_channel_tick_assert.svh"

module apu_tct_wave (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  apu_tct_pkg::t_cfg                i_cfg,
    input  logic                             i_fire,
    input  apu_tct_pkg::t_item               i_item,
    output logic [apu_tct_pkg::LevelW-1:0]   o_sample
);

    logic [apu_tct_pkg::CountW-1:0] r_count, n_count;
    logic [apu_tct_pkg::PhaseW-1:0] r_phase, n_phase;
    logic [apu_tct_pkg::LfsrW-1:0]  r_lfsr,  n_lfsr;
    logic [apu_tct_pkg::LevelW-1:0] r_level, n_level;

    logic [apu_tct_pkg::CountW-1:0] period;
    logic [apu_tct_pkg::LevelW-1:0] volume;
    logic [apu_tct_pkg::PhaseW-1:0] phase_inc;
    logic [apu_tct_pkg::LfsrW-1:0]  lfsr_seed;
    logic                           feedback;
    logic [4:0]                     duty_bit;
    logic                           tri_step;

    always_comb begin
        case (i_cfg.kind) inside
            apu_tct_pkg::KIND_NOISE:
                period = {1'b0, i_cfg.noise_period};
            apu_tct_pkg::KIND_TRIANGLE:
                period = {2'b00, i_cfg.wave_length} + 13'd1;
            default:
                period = {1'b0, i_cfg.wave_length, 1'b0} + 13'd2;
        endcase
    end

    assign volume = !i_item.length_active ? '0 :
                    (i_cfg.constant_volume ? i_cfg.fixed_volume : i_item.envelope_level);
    assign phase_inc = r_phase + 5'd1;
    assign duty_bit  = {i_cfg.duty_select, phase_inc[2:0]};
    assign tri_step  = i_item.length_active && i_item.linear_active && (period >= 13'd3);
    assign lfsr_seed = (r_lfsr == '0) ? 15'd1 : r_lfsr;
    assign feedback  = lfsr_seed[0] ^ (i_cfg.noise_mode ? lfsr_seed[6] : lfsr_seed[1]);

    always_comb begin
        n_count = r_count;
        n_phase = r_phase;
        n_lfsr  = r_lfsr;
        n_level = r_level;
        if (i_fire && i_item.channel_enabled) begin
            if (r_count != '0) begin
                n_count = r_count - 13'd1;
            end else begin
                n_count = period;
                case (i_cfg.kind) inside
                    apu_tct_pkg::KIND_PULSE0, apu_tct_pkg::KIND_PULSE1: begin
                        if (period < 13'd8) begin
                            n_level = apu_tct_pkg::MidLevel;
                        end else begin
                            n_phase = phase_inc;
                            n_level = apu_tct_pkg::DutyPatterns[duty_bit] ? volume : '0;
                        end
                    end
                    apu_tct_pkg::KIND_TRIANGLE: begin
                        if (tri_step) begin
                            n_phase = phase_inc;
                        end
                        n_level = n_phase[4] ? ~n_phase[3:0] : n_phase[3:0];
                    end
                    default: begin
                        n_lfsr  = {feedback, lfsr_seed[apu_tct_pkg::LfsrW-1:1]};
                        n_level = n_lfsr[0] ? '0 : volume;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_phase <= '0;
            r_lfsr  <= '0;
            r_level <= '0;
        end else begin
            r_count <= n_count;
            r_phase <= n_phase;
            r_lfsr  <= n_lfsr;
            r_level <= n_level;
        end
    end

    assign o_sample = i_item.channel_enabled ? n_level : apu_tct_pkg::MidLevel;

    // disabled ticks leave all channel state alone
    `APU_ASSERT_NEXT(a_disabled_holds, i_clk, i_rst_n, i_fire && !i_item.channel_enabled, $stable(r_count) && $stable(r_phase) && $stable(r_lfsr) && $stable(r_level))
    // counting down keeps the level and drops the count by one
    `APU_ASSERT_NEXT(a_countdown, i_clk, i_rst_n, i_fire && i_item.channel_enabled && r_count != '0, $stable(r_level) && r_count == $past(r_count) - 13'd1)
    // a noise update never leaves the shift register at zero
    `APU_ASSERT_NEXT(a_lfsr_live, i_clk, i_rst_n, i_fire && i_item.channel_enabled && r_count == '0 && i_cfg.kind == apu_tct_pkg::KIND_NOISE, r_lfsr != '0)

endmodule

>>> src/apu_tone_channel_tick.sv
// apu tone channel tick: top level
//
//  port     role      payload
//  i_in     sink      channel_enabled, length_active, linear_active, envelope_level
//  o_out    source    sample
//  i_cfg_*  write     index 0..6, data 12 bits
//
// one tick per cycle sustained while the output is not stalled; a tick's sample reaches the output
// through one input register stage and one result register around the level logic
// synchronous active-low reset clears config, channel state and both valid flags
// a stalled output holds its sample; the input register keeps taking ticks while free
`include "apu_tone_channel_tick_assert.svh"

module apu_tone_channel_tick (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    apu_tct_in_if.sink                       i_in,
    apu_tct_out_if.source                    o_out,
    input  logic                             i_cfg_we,
    input  logic [apu_tct_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [apu_tct_pkg::CfgDataW-1:0] i_cfg_data
);

    apu_tct_pkg::t_cfg  cfg;
    apu_tct_pkg::t_item r_in_item;
    logic               r_in_valid;
    logic               r_out_valid;
    logic [apu_tct_pkg::LevelW-1:0] r_out_sample;
    logic [apu_tct_pkg::LevelW-1:0] sample;
    logic               advance;
    logic               fire;

    assign advance    = !r_out_valid || o_out.ready;
    assign fire       = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;

    apu_tct_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    apu_tct_wave u_wave (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_fire   (fire),
        .i_item   (r_in_item),
        .o_sample (sample)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
        if (i_in.valid && i_in.ready) begin
            r_in_item <= '{channel_enabled: i_in.channel_enabled,
                           length_active:   i_in.length_active,
                           linear_active:   i_in.linear_active,
                           envelope_level:  i_in.envelope_level};
        end
        if (fire) begin
            r_out_sample <= sample;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.sample = r_out_sample;

    // a result only appears from a tick held in the input register
    `APU_ASSERT_SAME(a_out_from_in, i_clk, i_rst_n, $rose(r_out_valid), $past(r_in_valid))
    // a disabled tick yields the mid level
    `APU_ASSERT_NEXT(a_disabled_mid, i_clk, i_rst_n, fire && !r_in_item.channel_enabled, r_out_sample == apu_tct_pkg::MidLevel)
    // the input stage is never refused while the output side drains
    `APU_ASSERT_SAME(a_ready_when_free, i_clk, i_rst_n, advance, i_in.ready)

endmodule
